// File: rtl/core/mvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared types and constants for the MessagePack value skipper: header byte
// codes, class codes, framing phases and the decoded header record.
// ----------------------------------------------------------------------------
package mvs_pkg;

  localparam int unsigned PENDING_BITS = 40;
  localparam logic [PENDING_BITS-1:0] PENDING_MAX = '1;

  // header class codes
  localparam logic [2:0] CLS_SCALAR = 3'd0;
  localparam logic [2:0] CLS_NUMBER = 3'd1;
  localparam logic [2:0] CLS_STR    = 3'd2;
  localparam logic [2:0] CLS_BIN    = 3'd3;
  localparam logic [2:0] CLS_ARRAY  = 3'd4;
  localparam logic [2:0] CLS_MAP    = 3'd5;
  localparam logic [2:0] CLS_EXT    = 3'd6;

  // header byte codes and masks
  localparam logic [7:0] POS_FIXINT_MAX = 8'h7F;
  localparam logic [7:0] NEG_FIXINT_MIN = 8'hE0;
  localparam logic [7:0] MASK_TOP3      = 8'hE0;
  localparam logic [7:0] MASK_TOP4      = 8'hF0;
  localparam logic [7:0] FIXSTR_TAG     = 8'hA0;
  localparam logic [7:0] FIXARRAY_TAG   = 8'h90;
  localparam logic [7:0] FIXMAP_TAG     = 8'h80;
  localparam logic [7:0] MASK_FIXSTR    = 8'h1F;
  localparam logic [7:0] MASK_FIXCOUNT  = 8'h0F;

  localparam logic [7:0] HDR_NIL      = 8'hC0;
  localparam logic [7:0] HDR_UNUSED   = 8'hC1;
  localparam logic [7:0] HDR_FALSE    = 8'hC2;
  localparam logic [7:0] HDR_TRUE     = 8'hC3;
  localparam logic [7:0] HDR_BIN8     = 8'hC4;
  localparam logic [7:0] HDR_BIN16    = 8'hC5;
  localparam logic [7:0] HDR_BIN32    = 8'hC6;
  localparam logic [7:0] HDR_EXT8     = 8'hC7;
  localparam logic [7:0] HDR_EXT16    = 8'hC8;
  localparam logic [7:0] HDR_EXT32    = 8'hC9;
  localparam logic [7:0] HDR_FLOAT32  = 8'hCA;
  localparam logic [7:0] HDR_FLOAT64  = 8'hCB;
  localparam logic [7:0] HDR_UINT8    = 8'hCC;
  localparam logic [7:0] HDR_UINT16   = 8'hCD;
  localparam logic [7:0] HDR_UINT32   = 8'hCE;
  localparam logic [7:0] HDR_UINT64   = 8'hCF;
  localparam logic [7:0] HDR_INT8     = 8'hD0;
  localparam logic [7:0] HDR_INT16    = 8'hD1;
  localparam logic [7:0] HDR_INT32    = 8'hD2;
  localparam logic [7:0] HDR_INT64    = 8'hD3;
  localparam logic [7:0] HDR_FIXEXT1  = 8'hD4;
  localparam logic [7:0] HDR_FIXEXT2  = 8'hD5;
  localparam logic [7:0] HDR_FIXEXT4  = 8'hD6;
  localparam logic [7:0] HDR_FIXEXT8  = 8'hD7;
  localparam logic [7:0] HDR_FIXEXT16 = 8'hD8;
  localparam logic [7:0] HDR_STR8     = 8'hD9;
  localparam logic [7:0] HDR_STR16    = 8'hDA;
  localparam logic [7:0] HDR_STR32    = 8'hDB;
  localparam logic [7:0] HDR_ARRAY16  = 8'hDC;
  localparam logic [7:0] HDR_ARRAY32  = 8'hDD;
  localparam logic [7:0] HDR_MAP16    = 8'hDE;
  localparam logic [7:0] HDR_MAP32    = 8'hDF;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ACT_END     = 2'd0,
    ACT_PENDING = 2'd1,
    ACT_LENGTH  = 2'd2,
    ACT_PAYLOAD = 2'd3
  } action_e;

  typedef struct packed {
    logic [2:0] cls;
    action_e    act;
    logic [4:0] pay_len;
    logic [4:0] pend_add;
    logic [2:0] len_bytes;
    logic       bad;
  } hdr_dec_t;

endpackage

// File: rtl/core/mvs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvs_if
// Valid/ready channels of the value skipper: the input byte stream and the
// per-byte framing result.
// ----------------------------------------------------------------------------
interface mvs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface mvs_result_if;
  logic       valid;
  logic       ready;
  logic       is_header;
  logic [2:0] header_class;
  logic       value_done;
  logic       error;

  modport source (
    output valid, output is_header, output header_class, output value_done,
    output error, input ready
  );
  modport sink (
    input valid, input is_header, input header_class, input value_done,
    input error, output ready
  );
endinterface

// File: rtl/core/mvs_header_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvs_header_decode
// Classifies one MessagePack header byte and gives what follows it: an end
// of item, a pending count, a length field or a fixed payload size.
// ----------------------------------------------------------------------------
module mvs_header_decode import mvs_pkg::*; (
  input  logic [7:0] data_i,
  output hdr_dec_t   dec_o
);

  always_comb begin
    dec_o = '0;
    dec_o.cls = CLS_SCALAR;
    dec_o.act = ACT_END;
    if (data_i <= POS_FIXINT_MAX || data_i >= NEG_FIXINT_MIN) begin
      dec_o.act = ACT_END;
    end else if ((data_i & MASK_TOP3) == FIXSTR_TAG) begin
      dec_o.cls     = CLS_STR;
      dec_o.act     = ACT_PAYLOAD;
      dec_o.pay_len = 5'(data_i & MASK_FIXSTR);
    end else if ((data_i & MASK_TOP4) == FIXARRAY_TAG) begin
      dec_o.cls      = CLS_ARRAY;
      dec_o.act      = ACT_PENDING;
      dec_o.pend_add = {1'b0, 4'(data_i & MASK_FIXCOUNT)};
    end else if ((data_i & MASK_TOP4) == FIXMAP_TAG) begin
      dec_o.cls      = CLS_MAP;
      dec_o.act      = ACT_PENDING;
      dec_o.pend_add = {4'(data_i & MASK_FIXCOUNT), 1'b0};
    end else begin
      case (data_i)
        HDR_NIL, HDR_FALSE, HDR_TRUE: begin
          dec_o.act = ACT_END;
        end
        HDR_UNUSED: begin
          dec_o.act = ACT_END;
          dec_o.bad = 1'b1;
        end
        HDR_BIN8, HDR_BIN16, HDR_BIN32: begin
          dec_o.cls       = CLS_BIN;
          dec_o.act       = ACT_LENGTH;
          dec_o.len_bytes = (data_i == HDR_BIN8) ? 3'd1 : (data_i == HDR_BIN16) ? 3'd2 : 3'd4;
        end
        HDR_EXT8, HDR_EXT16, HDR_EXT32: begin
          dec_o.cls       = CLS_EXT;
          dec_o.act       = ACT_LENGTH;
          dec_o.len_bytes = (data_i == HDR_EXT8) ? 3'd1 : (data_i == HDR_EXT16) ? 3'd2 : 3'd4;
        end
        HDR_FLOAT32: begin
          dec_o.cls     = CLS_NUMBER;
          dec_o.act     = ACT_PAYLOAD;
          dec_o.pay_len = 5'd4;
        end
        HDR_FLOAT64: begin
          dec_o.cls     = CLS_NUMBER;
          dec_o.act     = ACT_PAYLOAD;
          dec_o.pay_len = 5'd8;
        end
        HDR_UINT8, HDR_UINT16, HDR_UINT32, HDR_UINT64,
        HDR_INT8, HDR_INT16, HDR_INT32, HDR_INT64: begin
          dec_o.cls     = CLS_NUMBER;
          dec_o.act     = ACT_PAYLOAD;
          dec_o.pay_len = 5'd1 << data_i[1:0];
        end
        HDR_FIXEXT1: begin
          dec_o.cls     = CLS_EXT;
          dec_o.act     = ACT_PAYLOAD;
          dec_o.pay_len = 5'd2;
        end
        HDR_FIXEXT2: begin
          dec_o.cls     = CLS_EXT;
          dec_o.act     = ACT_PAYLOAD;
          dec_o.pay_len = 5'd3;
        end
        HDR_FIXEXT4: begin
          dec_o.cls     = CLS_EXT;
          dec_o.act     = ACT_PAYLOAD;
          dec_o.pay_len = 5'd5;
        end
        HDR_FIXEXT8: begin
          dec_o.cls     = CLS_EXT;
          dec_o.act     = ACT_PAYLOAD;
          dec_o.pay_len = 5'd9;
        end
        HDR_FIXEXT16: begin
          dec_o.cls     = CLS_EXT;
          dec_o.act     = ACT_PAYLOAD;
          dec_o.pay_len = 5'd17;
        end
        HDR_STR8, HDR_STR16, HDR_STR32: begin
          dec_o.cls       = CLS_STR;
          dec_o.act       = ACT_LENGTH;
          dec_o.len_bytes = (data_i == HDR_STR8) ? 3'd1 : (data_i == HDR_STR16) ? 3'd2 : 3'd4;
        end
        HDR_ARRAY16, HDR_ARRAY32: begin
          dec_o.cls       = CLS_ARRAY;
          dec_o.act       = ACT_LENGTH;
          dec_o.len_bytes = (data_i == HDR_ARRAY16) ? 3'd2 : 3'd4;
        end
        HDR_MAP16, HDR_MAP32: begin
          dec_o.cls       = CLS_MAP;
          dec_o.act       = ACT_LENGTH;
          dec_o.len_bytes = (data_i == HDR_MAP16) ? 3'd2 : 3'd4;
        end
        default: begin
          dec_o.act = ACT_END;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/msgpack_value_skipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgpack_value_skipper
// Frames top-level MessagePack values in a byte stream. Each byte is held in
// the input register and its result in the result register. Throughput: one
// byte per clock while the result output is not stalled, the framing state
// (phase, length, payload and pending counters) being updated for each byte.
// Reset: asynchronous, active low; clears all framing state and the error.
// ----------------------------------------------------------------------------
module msgpack_value_skipper import mvs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mvs_byte_if.sink     in_i,
  mvs_result_if.source out_o
);

  logic                    in_valid_q;
  logic [7:0]              data_q;
  logic                    out_valid_q;
  logic                    advance;
  logic                    process;

  phase_e                  phase_q, phase_d;
  logic [2:0]              len_left_q, len_left_d;
  logic [31:0]             length_accum_q, length_accum_d;
  logic [2:0]              held_class_q, held_class_d;
  logic [32:0]             payload_left_q, payload_left_d;
  logic [PENDING_BITS-1:0] pending_q, pending_d;
  logic                    error_q, error_d;

  logic                    is_header_q, is_header_d;
  logic [2:0]              class_q, class_d;
  logic                    done_q, done_d;

  hdr_dec_t                dec;
  logic [31:0]             acc_new;
  logic                    item_end;
  logic                    start_en;
  logic [32:0]             start_len;
  logic                    add_en;
  logic [32:0]             add_val;
  logic                    err_set;
  logic [PENDING_BITS-1:0] pend_base;
  logic [PENDING_BITS:0]   pend_sum;

  mvs_header_decode u_decode (
    .data_i (data_q),
    .dec_o  (dec)
  );

  assign advance     = !out_valid_q || out_o.ready;
  assign process     = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;

  always_comb begin
    phase_d        = phase_q;
    len_left_d     = len_left_q;
    length_accum_d = length_accum_q;
    held_class_d   = held_class_q;
    payload_left_d = payload_left_q;
    is_header_d    = 1'b0;
    class_d        = CLS_SCALAR;
    acc_new        = {length_accum_q[23:0], data_q};
    item_end       = 1'b0;
    start_en       = 1'b0;
    start_len      = '0;
    add_en         = 1'b0;
    add_val        = '0;
    err_set        = 1'b0;
    pend_base      = pending_q;

    case (phase_q)
      PH_LENGTH: begin
        length_accum_d = acc_new;
        if (len_left_q <= 3'd1) begin
          phase_d    = PH_HEADER;
          len_left_d = '0;
          case (held_class_q)
            CLS_ARRAY: begin
              add_en   = 1'b1;
              add_val  = {1'b0, acc_new};
              item_end = 1'b1;
            end
            CLS_MAP: begin
              add_en   = 1'b1;
              add_val  = {acc_new, 1'b0};
              item_end = 1'b1;
            end
            CLS_EXT: begin
              start_en  = 1'b1;
              start_len = {1'b0, acc_new} + 33'd1;
            end
            default: begin
              start_en  = 1'b1;
              start_len = {1'b0, acc_new};
            end
          endcase
        end else begin
          len_left_d = len_left_q - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        if (payload_left_q <= 33'd1) begin
          payload_left_d = '0;
          phase_d        = PH_HEADER;
          item_end       = 1'b1;
        end else begin
          payload_left_d = payload_left_q - 33'd1;
        end
      end
      default: begin
        phase_d     = PH_HEADER;
        is_header_d = 1'b1;
        class_d     = dec.cls;
        err_set     = dec.bad;
        pend_base   = (pending_q == '0) ? '0 : pending_q - 1'b1;
        case (dec.act)
          ACT_PENDING: begin
            add_en   = 1'b1;
            add_val  = 33'(dec.pend_add);
            item_end = 1'b1;
          end
          ACT_LENGTH: begin
            held_class_d   = dec.cls;
            len_left_d     = dec.len_bytes;
            length_accum_d = '0;
            phase_d        = PH_LENGTH;
          end
          ACT_PAYLOAD: begin
            start_en  = 1'b1;
            start_len = 33'(dec.pay_len);
          end
          default: begin
            item_end = 1'b1;
          end
        endcase
      end
    endcase

    if (start_en) begin
      if (start_len == '0) begin
        phase_d  = PH_HEADER;
        item_end = 1'b1;
      end else begin
        payload_left_d = start_len;
        phase_d        = PH_PAYLOAD;
      end
    end

    pend_sum = {1'b0, pend_base} + (PENDING_BITS+1)'(add_val);
    if (add_en && pend_sum[PENDING_BITS]) begin
      pending_d = PENDING_MAX;
      err_set   = 1'b1;
    end else if (add_en) begin
      pending_d = pend_sum[PENDING_BITS-1:0];
    end else begin
      pending_d = pend_base;
    end

    error_d = error_q || err_set;
    done_d  = item_end && (pending_d == '0);
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      data_q <= in_i.data_byte;
    end
  end

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      len_left_q     <= '0;
      length_accum_q <= '0;
      held_class_q   <= CLS_SCALAR;
      payload_left_q <= '0;
      pending_q      <= '0;
      error_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (process) begin
        phase_q        <= phase_d;
        len_left_q     <= len_left_d;
        length_accum_q <= length_accum_d;
        held_class_q   <= held_class_d;
        payload_left_q <= payload_left_d;
        pending_q      <= pending_d;
        error_q        <= error_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (process) begin
      is_header_q <= is_header_d;
      class_q     <= class_d;
      done_q      <= done_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.is_header    = is_header_q;
  assign out_o.header_class = class_q;
  assign out_o.value_done   = done_q;
  assign out_o.error        = error_q;

`ifndef SYNTH
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_q |=> error_q)
    else $error("error flag cleared without reset");

  a_length_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LENGTH) |-> (len_left_q != '0))
    else $error("length phase with no length bytes left");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (payload_left_q != '0))
    else $error("payload phase with no payload bytes left");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while the held byte cannot move");
`endif

endmodule
